[hw/rtl/gwh_pkg.sv]
// ----------------------------------------------------------------------------
// gwh_pkg
// Shared constants, datapath command codes and control/status types for the
// growing weighted histogram.
// ----------------------------------------------------------------------------
`default_nettype none

package gwh_pkg;

  localparam int MAX_BINS = 256;
  localparam int IDX_W    = 8;     // bits to address one bin
  localparam int USED_W   = 9;     // bin count, 0..MAX_BINS
  localparam int CNT_W    = 32;    // per-bin count
  localparam int TOT_W    = 48;    // total weight
  localparam int DIVN_W   = 104;   // divider numerator
  localparam int DIVD_W   = 48;    // divider denominator
  localparam int STEP_W   = 7;     // divider step count

  localparam logic [TOT_W-1:0] TOTAL_MAX = '1;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;
  localparam logic [62:0]      VAR_MAX   = '1;

  // divider step counts for each use
  localparam logic [STEP_W-1:0] STEPS_BIN = 7'd32;
  localparam logic [STEP_W-1:0] STEPS_S1  = 7'd80;
  localparam logic [STEP_W-1:0] STEPS_ACC = 7'd104;

  // operation codes of an input word
  localparam logic [1:0] OPC_ADD    = 2'd0;
  localparam logic [1:0] OPC_CLEAR  = 2'd1;
  localparam logic [1:0] OPC_REPORT = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_START = 2'd0;
  localparam logic [1:0] CFG_WIDTH = 2'd1;
  localparam logic [1:0] CFG_MODE  = 2'd2;

  // datapath commands
  localparam logic [4:0] DP_NONE     = 5'd0;
  localparam logic [4:0] DP_LATCH    = 5'd1;
  localparam logic [4:0] DP_DIV_BIN  = 5'd2;
  localparam logic [4:0] DP_LEFT_CHK = 5'd3;
  localparam logic [4:0] DP_LEFT_AP  = 5'd4;
  localparam logic [4:0] DP_RIGHT_AP = 5'd5;
  localparam logic [4:0] DP_ADD_RD   = 5'd6;
  localparam logic [4:0] DP_ADD_WR   = 5'd7;
  localparam logic [4:0] DP_CLEAR    = 5'd8;
  localparam logic [4:0] DP_RPT_INIT = 5'd9;
  localparam logic [4:0] DP_BIN_RD   = 5'd10;
  localparam logic [4:0] DP_P1_MUL   = 5'd11;
  localparam logic [4:0] DP_P1_ACC   = 5'd12;
  localparam logic [4:0] DP_DIV_S1   = 5'd13;
  localparam logic [4:0] DP_MEAN     = 5'd14;
  localparam logic [4:0] DP_P2_SQ    = 5'd15;
  localparam logic [4:0] DP_P2_T     = 5'd16;
  localparam logic [4:0] DP_P2_ACC   = 5'd17;
  localparam logic [4:0] DP_DIV_ACC  = 5'd18;
  localparam logic [4:0] DP_VAR      = 5'd19;
  localparam logic [4:0] DP_LOAD_OUT = 5'd20;

  typedef struct packed {
    logic [4:0] op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] operation;
    logic       left;        // sample lies below the start
    logic       total_zero;
    logic       used_zero;
    logic       dropped;
    logic       i_last;      // walk index is on the last bin
    logic       div_done;
    logic       mul_done;
  } sts_t;

endpackage

`default_nettype wire

[hw/rtl/gwh_div.sv]
// ----------------------------------------------------------------------------
// gwh_div
// Restoring divider, one quotient bit per cycle. The numerator comes in left
// aligned; the step count sets how many of its top bits are used.
// ----------------------------------------------------------------------------
`default_nettype none

module gwh_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [gwh_pkg::DIVN_W-1:0]  num_i,
  input  wire logic [gwh_pkg::DIVD_W-1:0]  den_i,
  input  wire logic [gwh_pkg::STEP_W-1:0]  steps_i,
  output logic                             done,
  output logic [gwh_pkg::DIVN_W-1:0]       quo,
  output logic [gwh_pkg::DIVD_W-1:0]       rem
);

  logic                        busy_r;
  logic                        done_r;
  logic [gwh_pkg::STEP_W-1:0]  cnt_r;
  logic [gwh_pkg::DIVN_W-1:0]  num_r;
  logic [gwh_pkg::DIVD_W-1:0]  den_r;
  logic [gwh_pkg::DIVN_W-1:0]  quo_r;
  logic [gwh_pkg::DIVD_W-1:0]  rem_r;
  logic [gwh_pkg::DIVD_W:0]    trial;
  logic [gwh_pkg::DIVD_W:0]    diff;
  logic                        ge;

  // one trial subtract per cycle
  assign trial = {rem_r, num_r[gwh_pkg::DIVN_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= steps_i;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // data
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num_i;
      den_r <= den_i;
      quo_r <= '0;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[gwh_pkg::DIVD_W-1:0] : trial[gwh_pkg::DIVD_W-1:0];
      quo_r <= {quo_r[gwh_pkg::DIVN_W-2:0], ge};
      num_r <= {num_r[gwh_pkg::DIVN_W-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

[hw/rtl/gwh_mul.sv]
// ----------------------------------------------------------------------------
// gwh_mul
// 64x64 multiplier built from one 32x32 product per cycle, four partial
// products accumulated into a 128-bit result.
// ----------------------------------------------------------------------------
`default_nettype none

module gwh_mul (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [63:0]  a_i,
  input  wire logic [63:0]  b_i,
  output logic              done,
  output logic [127:0]      prod
);

  logic          busy_r;
  logic          done_r;
  logic [2:0]    cnt_r;
  logic [63:0]   a_r;
  logic [63:0]   b_r;
  logic [63:0]   pp_r;
  logic [1:0]    psh_r;
  logic [127:0]  acc_r;
  logic [31:0]   a_half;
  logic [31:0]   b_half;
  logic [127:0]  pp_pos;

  assign a_half = cnt_r[1] ? a_r[63:32] : a_r[31:0];
  assign b_half = cnt_r[0] ? b_r[63:32] : b_r[31:0];

  // place the previous partial product
  always_comb begin
    case (psh_r)
      2'd0:    pp_pos = {64'd0, pp_r};
      2'd1:    pp_pos = {32'd0, pp_r, 32'd0};
      2'd2:    pp_pos = {pp_r, 64'd0};
      default: pp_pos = '0;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // partial products and accumulation
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a_i;
      b_r   <= b_i;
      acc_r <= '0;
    end else if (busy_r) begin
      if (cnt_r != 3'd4) begin
        pp_r  <= 64'(a_half) * 64'(b_half);
        psh_r <= {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};
      end
      if (cnt_r != 3'd0) begin
        acc_r <= acc_r + pp_pos;
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

`default_nettype wire

[hw/rtl/gwh_datapath.sv]
// ----------------------------------------------------------------------------
// gwh_datapath
// Histogram state, bin memory with valid flags, shared divider and
// multiplier, report accumulators and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gwh_datapath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [31:0]         cfg_data,
  input  wire logic [1:0]          in_operation,
  input  wire logic signed [31:0]  in_sample_value,
  input  wire logic [15:0]         in_weight,
  input  wire gwh_pkg::cmd_t       cmd,
  output gwh_pkg::sts_t            sts,
  output logic [7:0]               out_bin_index,
  output logic [8:0]               out_bins_in_use,
  output logic                     out_dropped,
  output logic [47:0]              out_total_weight_out,
  output logic signed [31:0]       out_mean_value,
  output logic [62:0]              out_variance_value
);

  // state
  logic signed [31:0]              start_r;
  logic [30:0]                     bw_r;
  logic                            disc_r;
  logic [gwh_pkg::USED_W-1:0]      used_r;
  logic [gwh_pkg::TOT_W-1:0]       total_r;
  logic [gwh_pkg::IDX_W-1:0]       base_r;
  logic [gwh_pkg::MAX_BINS-1:0]    valid_r;
  logic [gwh_pkg::CNT_W-1:0]       mem [gwh_pkg::MAX_BINS];

  // per-word working registers
  logic [1:0]                      op_r;
  logic signed [31:0]              smp_r;
  logic [15:0]                     wgt_r;
  logic [gwh_pkg::USED_W-1:0]      k_r;
  logic                            big_r;
  logic [39:0]                     kbw_r;
  logic [gwh_pkg::IDX_W-1:0]       idx_r;
  logic                            drop_r;
  logic [gwh_pkg::IDX_W-1:0]       i_r;
  logic [39:0]                     d_r;
  logic [40:0]                     m_r;
  logic [79:0]                     s1_r;
  logic [103:0]                    acc_r;
  logic [gwh_pkg::CNT_W-1:0]       rd_r;
  logic                            rdv_r;
  logic signed [31:0]              mean_r;
  logic [62:0]                     var_r;

  // result register
  logic [7:0]                      o_bin_r;
  logic [8:0]                      o_used_r;
  logic                            o_drop_r;
  logic [47:0]                     o_total_r;
  logic signed [31:0]              o_mean_r;
  logic [62:0]                     o_var_r;

  // shared units
  logic                            div_start;
  logic [gwh_pkg::DIVN_W-1:0]      div_num;
  logic [gwh_pkg::DIVD_W-1:0]      div_den;
  logic [gwh_pkg::STEP_W-1:0]      div_steps;
  logic                            div_done;
  logic [gwh_pkg::DIVN_W-1:0]      quo;
  logic [gwh_pkg::DIVD_W-1:0]      rem;
  logic                            mul_start;
  logic [63:0]                     mul_a;
  logic [63:0]                     mul_b;
  logic                            mul_done;
  logic [127:0]                    prod;

  // combinational helpers
  logic [30:0]                     bw_eff;
  logic [39:0]                     half;
  logic [32:0]                     diff33;
  logic [31:0]                     gap;
  logic [32:0]                     kfull;
  logic [33:0]                     ksum;
  logic signed [41:0]              ns42;
  logic                            left_fail;
  logic                            right_fail;
  logic                            grow_left;
  logic                            grow_right;
  logic [gwh_pkg::IDX_W-1:0]       base_left;
  logic [gwh_pkg::IDX_W-1:0]       clr_base;
  logic [gwh_pkg::IDX_W-1:0]       lrel;
  logic [gwh_pkg::MAX_BINS-1:0]    clr_mask;
  logic [gwh_pkg::IDX_W-1:0]       rd_addr;
  logic                            rd_en;
  logic [gwh_pkg::CNT_W-1:0]       cnt_val;
  logic [gwh_pkg::CNT_W:0]         csum;
  logic [gwh_pkg::TOT_W:0]         tsum;
  logic                            add_wr;
  logic [40:0]                     d41;
  logic [40:0]                     mag;
  logic signed [41:0]              msum;
  logic                            cfg_clear;

  assign bw_eff = (bw_r == '0) ? 31'd1 : bw_r;
  assign half   = disc_r ? 40'd0 : 40'(bw_eff);

  // binning distance from the start
  assign diff33 = {smp_r[31], smp_r} - {start_r[31], start_r};
  assign gap    = diff33[32] ? 32'((~diff33) + 33'd1) : diff33[31:0];

  // left growth checks
  assign kfull = {1'b0, quo[31:0]} + {32'd0, (rem != '0)};
  assign ksum  = {1'b0, kfull} + 34'(used_r);
  assign ns42  = $signed({{10{start_r[31]}}, start_r}) - $signed({2'b00, kbw_r});
  assign left_fail  = big_r || (ns42 < -42'sd2147483648);
  assign right_fail = (quo[31:8] != '0);
  assign grow_left  = (cmd.op == gwh_pkg::DP_LEFT_AP) && !left_fail;
  assign grow_right = (cmd.op == gwh_pkg::DP_RIGHT_AP) && !right_fail &&
                      ({1'b0, quo[7:0]} >= used_r);
  assign base_left  = base_r - k_r[gwh_pkg::IDX_W-1:0];
  assign clr_base   = grow_left ? base_left : base_r;

  // entries that become fresh bins read as zero
  always_comb begin
    lrel = '0;
    for (int p = 0; p < gwh_pkg::MAX_BINS; p++) begin
      lrel = gwh_pkg::IDX_W'(p) - clr_base;
      clr_mask[p] = grow_left ? ({1'b0, lrel} < k_r) :
                    (grow_right && ({1'b0, lrel} >= used_r) && (lrel <= quo[7:0]));
    end
  end

  // bin memory access; read data held until the next read command
  assign rd_addr = base_r + ((cmd.op == gwh_pkg::DP_BIN_RD) ? i_r : idx_r);
  assign rd_en   = (cmd.op == gwh_pkg::DP_BIN_RD) || (cmd.op == gwh_pkg::DP_ADD_RD);
  assign cnt_val = rdv_r ? rd_r : '0;
  assign csum    = {1'b0, cnt_val} + 33'(wgt_r);
  assign tsum    = {1'b0, total_r} + 49'(wgt_r);
  assign add_wr  = (cmd.op == gwh_pkg::DP_ADD_WR);

  always_ff @(posedge clk) begin
    if (add_wr) begin
      mem[rd_addr] <= csum[gwh_pkg::CNT_W] ? gwh_pkg::COUNT_MAX : csum[gwh_pkg::CNT_W-1:0];
    end
    if (rd_en) begin
      rd_r  <= mem[rd_addr];
      rdv_r <= valid_r[rd_addr];
    end
  end

  // report helpers
  assign d41  = {1'b0, d_r};
  assign mag  = (d41 >= m_r) ? (d41 - m_r) : (m_r - d41);
  assign msum = $signed({{10{start_r[31]}}, start_r}) + $signed({2'b00, quo[40:1]});

  // divider operands
  always_comb begin
    div_start = 1'b0;
    div_num   = {acc_r};
    div_den   = total_r;
    div_steps = gwh_pkg::STEPS_ACC;
    case (cmd.op)
      gwh_pkg::DP_DIV_BIN: begin
        div_start = 1'b1;
        div_num   = {gap, 72'd0};
        div_den   = {17'd0, bw_eff};
        div_steps = gwh_pkg::STEPS_BIN;
      end
      gwh_pkg::DP_DIV_S1: begin
        div_start = 1'b1;
        div_num   = {s1_r, 24'd0};
        div_steps = gwh_pkg::STEPS_S1;
      end
      gwh_pkg::DP_DIV_ACC: begin
        div_start = 1'b1;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // multiplier operands
  always_comb begin
    mul_start = 1'b0;
    mul_a     = 64'(d_r);
    mul_b     = 64'(cnt_val);
    case (cmd.op)
      gwh_pkg::DP_P1_MUL: begin
        mul_start = 1'b1;
      end
      gwh_pkg::DP_P2_SQ: begin
        mul_start = 1'b1;
        mul_a     = 64'(mag);
        mul_b     = 64'(mag);
      end
      gwh_pkg::DP_P2_T: begin
        mul_start = 1'b1;
        mul_a     = prod[81:18];
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  gwh_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .steps_i (div_steps),
    .done    (div_done),
    .quo     (quo),
    .rem     (rem)
  );

  gwh_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  assign cfg_clear = cfg_we && (cfg_index == gwh_pkg::CFG_START);

  // histogram state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      bw_r    <= 31'd65536;
      disc_r  <= 1'b0;
      used_r  <= '0;
      total_r <= '0;
      base_r  <= '0;
      valid_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        gwh_pkg::CFG_START: begin
          start_r <= cfg_data;
          used_r  <= '0;
          total_r <= '0;
          valid_r <= '0;
        end
        gwh_pkg::CFG_WIDTH: bw_r   <= cfg_data[30:0];
        gwh_pkg::CFG_MODE:  disc_r <= cfg_data[0];
        default: begin
        end
      endcase
    end else begin
      case (cmd.op)
        gwh_pkg::DP_CLEAR: begin
          used_r  <= '0;
          total_r <= '0;
          valid_r <= '0;
        end
        gwh_pkg::DP_LEFT_AP: begin
          if (!left_fail) begin
            start_r <= ns42[31:0];
            base_r  <= base_left;
            used_r  <= used_r + k_r;
            valid_r <= valid_r & ~clr_mask;
          end
        end
        gwh_pkg::DP_RIGHT_AP: begin
          if (grow_right) begin
            used_r  <= {1'b0, quo[7:0]} + 9'd1;
            valid_r <= valid_r & ~clr_mask;
          end
        end
        gwh_pkg::DP_ADD_WR: begin
          total_r          <= tsum[gwh_pkg::TOT_W] ? gwh_pkg::TOTAL_MAX
                                                   : tsum[gwh_pkg::TOT_W-1:0];
          valid_r[rd_addr] <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      gwh_pkg::DP_LATCH: begin
        op_r   <= in_operation;
        smp_r  <= in_sample_value;
        wgt_r  <= in_weight;
        idx_r  <= '0;
        drop_r <= 1'b0;
        mean_r <= '0;
        var_r  <= '0;
      end
      gwh_pkg::DP_LEFT_CHK: begin
        k_r   <= kfull[gwh_pkg::USED_W-1:0];
        big_r <= (ksum > 34'(gwh_pkg::MAX_BINS));
        kbw_r <= 40'(kfull[gwh_pkg::USED_W-1:0]) * 40'(bw_eff);
      end
      gwh_pkg::DP_LEFT_AP: begin
        idx_r  <= '0;
        drop_r <= left_fail;
      end
      gwh_pkg::DP_RIGHT_AP: begin
        idx_r  <= right_fail ? '0 : quo[7:0];
        drop_r <= right_fail;
      end
      gwh_pkg::DP_RPT_INIT: begin
        i_r  <= '0;
        d_r  <= half;
        s1_r <= '0;
      end
      gwh_pkg::DP_P1_ACC: begin
        s1_r <= s1_r + prod[79:0];
        d_r  <= d_r + {8'd0, bw_eff, 1'b0};
        i_r  <= i_r + 1'b1;
      end
      gwh_pkg::DP_MEAN: begin
        m_r    <= quo[40:0];
        mean_r <= (msum > 42'sd2147483647) ? 32'sh7FFFFFFF : msum[31:0];
        i_r    <= '0;
        d_r    <= half;
        acc_r  <= '0;
      end
      gwh_pkg::DP_P2_ACC: begin
        acc_r <= acc_r + prod[103:0];
        d_r   <= d_r + {8'd0, bw_eff, 1'b0};
        i_r   <= i_r + 1'b1;
      end
      gwh_pkg::DP_VAR: begin
        var_r <= (quo[103:63] != '0) ? gwh_pkg::VAR_MAX : quo[62:0];
      end
      gwh_pkg::DP_LOAD_OUT: begin
        o_bin_r   <= idx_r;
        o_used_r  <= used_r;
        o_drop_r  <= drop_r;
        o_total_r <= total_r;
        o_mean_r  <= mean_r;
        o_var_r   <= var_r;
      end
      default: begin
      end
    endcase
  end

  // status to the controller
  always_comb begin
    sts.operation  = op_r;
    sts.left       = diff33[32];
    sts.total_zero = (total_r == '0);
    sts.used_zero  = (used_r == '0);
    sts.dropped    = drop_r;
    sts.i_last     = ({1'b0, i_r} == (used_r - 9'd1));
    sts.div_done   = div_done;
    sts.mul_done   = mul_done;
  end

  assign out_bin_index        = o_bin_r;
  assign out_bins_in_use      = o_used_r;
  assign out_dropped          = o_drop_r;
  assign out_total_weight_out = o_total_r;
  assign out_mean_value       = o_mean_r;
  assign out_variance_value   = o_var_r;

endmodule

`default_nettype wire

[hw/rtl/gwh_ctrl.sv]
// ----------------------------------------------------------------------------
// gwh_ctrl
// Sequencer: accepts input words, steps the datapath through binning, clearing or
// the two report passes, and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module gwh_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  input  wire gwh_pkg::sts_t  sts,
  output gwh_pkg::cmd_t       cmd
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DECODE  = 5'd1;
  localparam logic [4:0] S_BIN_W   = 5'd2;
  localparam logic [4:0] S_LEFT_AP = 5'd3;
  localparam logic [4:0] S_ADD_RD  = 5'd4;
  localparam logic [4:0] S_ADD_WR  = 5'd5;
  localparam logic [4:0] S_P1_RD   = 5'd6;
  localparam logic [4:0] S_P1_MUL  = 5'd7;
  localparam logic [4:0] S_P1_MW   = 5'd8;
  localparam logic [4:0] S_P1_DIV  = 5'd9;
  localparam logic [4:0] S_P1_DW   = 5'd10;
  localparam logic [4:0] S_P2_RD   = 5'd11;
  localparam logic [4:0] S_P2_SQ   = 5'd12;
  localparam logic [4:0] S_P2_SW   = 5'd13;
  localparam logic [4:0] S_P2_TW   = 5'd14;
  localparam logic [4:0] S_P2_DIV  = 5'd15;
  localparam logic [4:0] S_P2_DW   = 5'd16;
  localparam logic [4:0] S_FIN     = 5'd17;

  logic [4:0] state_r;
  logic [4:0] state_nxt;
  logic       ov_r;
  logic       ov_nxt;

  // next state and datapath command
  always_comb begin
    state_nxt = state_r;
    cmd.op    = gwh_pkg::DP_NONE;
    ov_nxt    = ov_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = gwh_pkg::DP_LATCH;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.operation)
          gwh_pkg::OPC_ADD: begin
            cmd.op    = gwh_pkg::DP_DIV_BIN;
            state_nxt = S_BIN_W;
          end
          gwh_pkg::OPC_CLEAR: begin
            cmd.op    = gwh_pkg::DP_CLEAR;
            state_nxt = S_FIN;
          end
          gwh_pkg::OPC_REPORT: begin
            if (sts.total_zero || sts.used_zero) begin
              state_nxt = S_FIN;
            end else begin
              cmd.op    = gwh_pkg::DP_RPT_INIT;
              state_nxt = S_P1_RD;
            end
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_BIN_W: begin
        if (sts.div_done) begin
          if (sts.left) begin
            cmd.op    = gwh_pkg::DP_LEFT_CHK;
            state_nxt = S_LEFT_AP;
          end else begin
            cmd.op    = gwh_pkg::DP_RIGHT_AP;
            state_nxt = S_ADD_RD;
          end
        end
      end
      S_LEFT_AP: begin
        cmd.op    = gwh_pkg::DP_LEFT_AP;
        state_nxt = S_ADD_RD;
      end
      S_ADD_RD: begin
        if (sts.dropped) begin
          state_nxt = S_FIN;
        end else begin
          cmd.op    = gwh_pkg::DP_ADD_RD;
          state_nxt = S_ADD_WR;
        end
      end
      S_ADD_WR: begin
        cmd.op    = gwh_pkg::DP_ADD_WR;
        state_nxt = S_FIN;
      end
      // first pass: weighted sum of bin positions
      S_P1_RD: begin
        cmd.op    = gwh_pkg::DP_BIN_RD;
        state_nxt = S_P1_MUL;
      end
      S_P1_MUL: begin
        cmd.op    = gwh_pkg::DP_P1_MUL;
        state_nxt = S_P1_MW;
      end
      S_P1_MW: begin
        if (sts.mul_done) begin
          cmd.op    = gwh_pkg::DP_P1_ACC;
          state_nxt = sts.i_last ? S_P1_DIV : S_P1_RD;
        end
      end
      S_P1_DIV: begin
        cmd.op    = gwh_pkg::DP_DIV_S1;
        state_nxt = S_P1_DW;
      end
      S_P1_DW: begin
        if (sts.div_done) begin
          cmd.op    = gwh_pkg::DP_MEAN;
          state_nxt = S_P2_RD;
        end
      end
      // second pass: weighted squared deviations
      S_P2_RD: begin
        cmd.op    = gwh_pkg::DP_BIN_RD;
        state_nxt = S_P2_SQ;
      end
      S_P2_SQ: begin
        cmd.op    = gwh_pkg::DP_P2_SQ;
        state_nxt = S_P2_SW;
      end
      S_P2_SW: begin
        if (sts.mul_done) begin
          cmd.op    = gwh_pkg::DP_P2_T;
          state_nxt = S_P2_TW;
        end
      end
      S_P2_TW: begin
        if (sts.mul_done) begin
          cmd.op    = gwh_pkg::DP_P2_ACC;
          state_nxt = sts.i_last ? S_P2_DIV : S_P2_RD;
        end
      end
      S_P2_DIV: begin
        cmd.op    = gwh_pkg::DP_DIV_ACC;
        state_nxt = S_P2_DW;
      end
      S_P2_DW: begin
        if (sts.div_done) begin
          cmd.op    = gwh_pkg::DP_VAR;
          state_nxt = S_FIN;
        end
      end
      // hand the word over once the result register is free
      S_FIN: begin
        if (!ov_r || !out_stall) begin
          cmd.op    = gwh_pkg::DP_LOAD_OUT;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ov_r;

endmodule

`default_nettype wire

[hw/rtl/growing_weighted_histogram_core.sv]
// ----------------------------------------------------------------------------
// growing_weighted_histogram_core
// Add: the result waits on the 32-step bin divider.
// Clear and unknown operations use neither the divider nor the multiplier.
// Report: time grows with the bins in use, set by the shared multiplier and
//   the 80- and 104-step divisions; one word at a time.
// Reset is synchronous; bins are emptied at once through per-bin valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module growing_weighted_histogram_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [31:0]         cfg_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          in_operation,
  input  wire logic signed [31:0]  in_sample_value,
  input  wire logic [15:0]         in_weight,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [7:0]               out_bin_index,
  output logic [8:0]               out_bins_in_use,
  output logic                     out_dropped,
  output logic [47:0]              out_total_weight_out,
  output logic signed [31:0]       out_mean_value,
  output logic [62:0]              out_variance_value
);

  gwh_pkg::cmd_t cmd;
  gwh_pkg::sts_t sts;

  gwh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  gwh_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_operation         (in_operation),
    .in_sample_value      (in_sample_value),
    .in_weight            (in_weight),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_bin_index        (out_bin_index),
    .out_bins_in_use      (out_bins_in_use),
    .out_dropped          (out_dropped),
    .out_total_weight_out (out_total_weight_out),
    .out_mean_value       (out_mean_value),
    .out_variance_value   (out_variance_value)
  );

endmodule

`default_nettype wire

[sim/growing_weighted_histogram_core_checker.sv]
// ----------------------------------------------------------------------------
// growing_weighted_histogram_core_checker
// Watches the configuration port and both word channels of the histogram
// core. It keeps its own copy of the bins and registers, predicts the result
// word of every accepted input word, and compares it field by field.
// ----------------------------------------------------------------------------
module growing_weighted_histogram_core_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_sample_value,
  input  logic [15:0] in_weight,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_bin_index,
  input  logic [8:0]  out_bins_in_use,
  input  logic        out_dropped,
  input  logic [47:0] out_total_weight_out,
  input  logic [31:0] out_mean_value,
  input  logic [62:0] out_variance_value,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]  bin_index;
    logic [8:0]  bins_in_use;
    logic        dropped;
    logic [47:0] total;
    logic [31:0] mean;
    logic [62:0] variance;
  } hist_word_t;

  hist_word_t expected_words[$];

  // shadow of the registers and the histogram
  longint     init_start;
  longint     width_reg;
  bit         lower_edge_mode;
  bit [31:0]  counts [gwh_pkg::MAX_BINS];
  longint     start_pos;
  int         used;
  bit [47:0]  total_w;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic void empty_hist();
    foreach (counts[i]) counts[i] = '0;
    used    = 0;
    total_w = '0;
  endfunction

  function automatic bit [63:0] sat_div(input bit [127:0] num, input bit [47:0] den);
    bit [127:0] q;
    q = num / {80'd0, den};
    return (q[127:64] != 0) ? '1 : q[63:0];
  endfunction

  // add one sample; returns 0 when refused
  function automatic bit bin_sample(input longint v, input longint unsigned w,
                                    output int idx);
    longint bw;
    longint gap, k, ns;
    bw  = (width_reg == 0) ? 1 : width_reg;
    idx = 0;
    if (v < start_pos) begin
      gap = start_pos - v;
      k   = (gap + bw - 1) / bw;
      ns  = start_pos - k * bw;
      if (used + k > gwh_pkg::MAX_BINS || ns < -64'sd2147483648) return 0;
      for (int j = used; j > 0; j--) counts[j - 1 + k] = counts[j - 1];
      for (int j = 0; j < k; j++) counts[j] = '0;
      used      = used + int'(k);
      start_pos = ns;
    end else begin
      k = (v - start_pos) / bw;
      if (k >= used) begin
        if (k + 1 > gwh_pkg::MAX_BINS) return 0;
        for (int j = used; j <= k; j++) counts[j] = '0;
        used = int'(k) + 1;
      end
      idx = int'(k);
    end
    counts[idx] = ({32'd0, counts[idx]} + w > 64'(gwh_pkg::COUNT_MAX)) ? gwh_pkg::COUNT_MAX
                                                              : counts[idx] + 32'(w);
    total_w = ({16'd0, total_w} + w > 64'(gwh_pkg::TOTAL_MAX)) ? gwh_pkg::TOTAL_MAX
                                                                : total_w + 48'(w);
    return 1;
  endfunction

  // weighted mean and variance over the bins in use
  function automatic void mean_var(output logic [31:0] mean_o, output logic [62:0] var_o);
    longint unsigned bw, half, d, mag, m;
    bit [127:0] s1, acc, sq;
    longint mean;
    mean_o = '0;
    var_o  = '0;
    if (total_w == 0) return;
    bw   = (width_reg == 0) ? 1 : width_reg;
    half = lower_edge_mode ? 0 : bw;
    s1   = '0;
    acc  = '0;
    for (int i = 0; i < used; i++) begin
      d  = 2 * longint'(i) * bw + half;
      s1 += 128'(d) * 128'(counts[i]);
    end
    m    = sat_div(s1, total_w);
    mean = start_pos + longint'(m >> 1);
    if (mean > 64'sd2147483647) mean = 64'sd2147483647;
    mean_o = mean[31:0];
    for (int i = 0; i < used; i++) begin
      d   = 2 * longint'(i) * bw + half;
      mag = (d >= m) ? d - m : m - d;
      sq  = 128'(mag) * 128'(mag);
      acc += (sq >> 18) * 128'(counts[i]);
    end
    m = sat_div(acc, total_w);
    var_o = (m > 64'(gwh_pkg::VAR_MAX)) ? gwh_pkg::VAR_MAX : m[62:0];
  endfunction

  function automatic hist_word_t predict_word(input logic [1:0] op, input logic [31:0] v,
                                              input logic [15:0] w);
    hist_word_t r;
    int idx;
    r = '0;
    case (op)
      gwh_pkg::OPC_ADD: begin
        if (bin_sample(longint'(signed'(v)), w, idx)) r.bin_index = idx[7:0];
        else r.dropped = 1'b1;
      end
      gwh_pkg::OPC_CLEAR:  empty_hist();
      gwh_pkg::OPC_REPORT: mean_var(r.mean, r.variance);
      default: ;
    endcase
    r.bins_in_use = used[8:0];
    r.total       = total_w;
    return r;
  endfunction

  always @(posedge clk) begin
    hist_word_t want;
    if (!rst_n) begin
      init_start      = 0;
      width_reg       = 65536;
      lower_edge_mode = 0;
      start_pos       = 0;
      empty_hist();
      expected_words.delete();
      fail_count = 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          gwh_pkg::CFG_START: begin
            init_start = longint'(signed'(cfg_data));
            start_pos  = init_start;
            empty_hist();
          end
          gwh_pkg::CFG_WIDTH: width_reg = longint'(cfg_data[30:0]);
          gwh_pkg::CFG_MODE:  lower_edge_mode = cfg_data[0];
          default: ;
        endcase
      end
      // accepted input word
      if (in_valid && !in_stall)
        expected_words.push_back(predict_word(in_operation, in_sample_value, in_weight));
      // accepted result word
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected result word", 0, 0);
        end else begin
          want = expected_words.pop_front();
          if (out_bin_index != want.bin_index)
            report_mismatch("bin_index", out_bin_index, want.bin_index);
          if (out_bins_in_use != want.bins_in_use)
            report_mismatch("bins_in_use", out_bins_in_use, want.bins_in_use);
          if (out_dropped != want.dropped)
            report_mismatch("dropped", out_dropped, want.dropped);
          if (out_total_weight_out != want.total)
            report_mismatch("total_weight_out", out_total_weight_out, want.total);
          if (out_mean_value != want.mean)
            report_mismatch("mean_value", out_mean_value, want.mean);
          if (out_variance_value != want.variance)
            report_mismatch("variance_value", out_variance_value, want.variance);
        end
      end
    end
    pending = expected_words.size();
  end

endmodule

[sim/growing_weighted_histogram_core_tb.sv]
// ----------------------------------------------------------------------------
// growing_weighted_histogram_core_tb
// Drives the histogram core through several register settings with directed
// and random word streams and random idling on both channels; a checker
// beside the core predicts and compares every result word.
// ----------------------------------------------------------------------------
module growing_weighted_histogram_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OPC_UNKNOWN = 2'd3;
  localparam int IDLE_LIMIT = 20000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  in_operation = '0;
  logic [31:0] in_sample_value = '0;
  logic [15:0] in_weight = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [7:0]  out_bin_index;
  logic [8:0]  out_bins_in_use;
  logic        out_dropped;
  logic [47:0] out_total_weight_out;
  logic [31:0] out_mean_value;
  logic [62:0] out_variance_value;
  int          fail_count;
  int          pending;

  bit          no_idle;
  longint      cur_start;
  longint      cur_width;
  int          stall_left;
  int          idle_cycles;

  growing_weighted_histogram_core dut (.*);
  growing_weighted_histogram_core_checker chk (.*);

  initial forever #2 clk = ~clk;

  // result side back-pressure
  always @(posedge clk) begin
    if (out_valid && !out_stall) stall_left = no_idle ? 0 : $urandom_range(0, 11);
    else if (stall_left > 0) stall_left--;
    out_stall <= (stall_left != 0);
  end

  // watchdog: cycles without any accepted word
  always @(posedge clk) begin
    if (cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("growing_weighted_histogram_core regression: fail");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == gwh_pkg::CFG_START) cur_start = longint'(signed'(val));
    if (idx == gwh_pkg::CFG_WIDTH) cur_width = (val[30:0] == 0) ? 1 : longint'(val[30:0]);
  endtask

  task automatic set_config(input logic [31:0] s, input logic [31:0] bw, input bit mode);
    write_reg(gwh_pkg::CFG_START, s);
    write_reg(gwh_pkg::CFG_WIDTH, bw);
    write_reg(gwh_pkg::CFG_MODE, {31'd0, mode});
  endtask

  // hand one word to the core
  task automatic send_word(input logic [1:0] op, input logic [31:0] v,
                           input logic [15:0] w);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_sample_value <= v;
    in_weight       <= w;
    do @(posedge clk); while (in_stall);
  endtask

  // the checker counts the last word after its accept; wait until nothing is pending
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // sample near the occupied range, mostly inside a few hundred bins
  function automatic logic [31:0] near_sample();
    longint v;
    v = cur_start + (longint'($urandom_range(0, 300)) - 40) * cur_width
        + longint'($urandom_range(0, 32'(cur_width - 1)));
    if ($urandom_range(0, 9) == 0 || v < -64'sd2147483648 || v > 64'sd2147483647)
      return $urandom;
    return v[31:0];
  endfunction

  function automatic logic [15:0] rand_weight();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_phase(input int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 84)      send_word(gwh_pkg::OPC_ADD, near_sample(), rand_weight());
      else if (sel < 92) send_word(gwh_pkg::OPC_REPORT, $urandom, 16'($urandom));
      else if (sel < 97) send_word(gwh_pkg::OPC_CLEAR, $urandom, 16'($urandom));
      else               send_word(OPC_UNKNOWN, $urandom, 16'($urandom));
    end
    no_idle = 0;
    drain();
  endtask

  initial begin
    cur_start = 0;
    cur_width = 65536;
    no_idle   = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words on reset settings
    send_word(gwh_pkg::OPC_REPORT, 32'd0, 16'd0);          // empty histogram
    send_word(gwh_pkg::OPC_ADD, 32'd0, 16'hFFFF);          // first bin appended
    send_word(gwh_pkg::OPC_ADD, 32'h0001_0000, 16'd1);     // exactly on the upper edge
    send_word(gwh_pkg::OPC_ADD, 32'hFFFD_0000, 16'd7);     // grows on the left
    send_word(gwh_pkg::OPC_ADD, 32'h0003_8000, 16'd0);     // zero weight still grows
    send_word(gwh_pkg::OPC_REPORT, 32'd0, 16'd0);
    send_word(gwh_pkg::OPC_ADD, 32'h7FFF_FFFF, 16'd3);     // far right, dropped
    send_word(gwh_pkg::OPC_ADD, 32'h8000_0000, 16'd3);     // far left, dropped
    send_word(OPC_UNKNOWN, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(gwh_pkg::OPC_CLEAR, 32'd0, 16'd0);
    send_word(gwh_pkg::OPC_REPORT, 32'd0, 16'd0);          // zero total
    send_word(gwh_pkg::OPC_ADD, 32'hFFFC_0000, 16'd5);     // start kept after clear
    send_word(gwh_pkg::OPC_ADD, 32'h00FB_0000, 16'd9);     // fill up to the limit
    send_word(gwh_pkg::OPC_REPORT, 32'd0, 16'd0);
    drain();
    random_phase(150);

    // start just above the bottom of the range
    set_config(32'h8000_000A, 32'h0001_0000, 1'b0);
    send_word(gwh_pkg::OPC_ADD, 32'h8000_0000, 16'd4);     // start would leave the range
    send_word(gwh_pkg::OPC_ADD, 32'h8000_000A, 16'd4);
    send_word(gwh_pkg::OPC_REPORT, 32'd0, 16'd0);
    drain();
    random_phase(120);

    set_config(32'h8000_0000, 32'd1, 1'b1);
    random_phase(150);
    set_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    random_phase(150);
    set_config($urandom, 32'd0, 1'b1);            // zero width acts as one
    random_phase(150);
    for (int p = 0; p < 4; p++) begin
      case ($urandom_range(0, 2))
        0:       set_config($urandom, 32'($urandom_range(1, 4096)), 1'($urandom));
        1:       set_config(32'($urandom_range(0, 2000000)) - 32'd1000000,
                            32'h0001_0000, 1'($urandom));
        default: set_config($urandom, $urandom, 1'($urandom));
      endcase
      random_phase(160);
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("growing_weighted_histogram_core regression: pass");
    else
      $display("growing_weighted_histogram_core regression: fail");
    $finish;
  end

endmodule
